// ===== hdl/gcnq_pkg.sv =====
// shared constants, types and address helpers for the grid cell index store
// no dependencies; imported by every other file of the block but gcnq_ram
package gcnq_pkg;

    localparam int MAX_ROWS       = 64;
    localparam int MAX_COLS       = 64;
    localparam int MAX_HALF_WIDTH = 4;
    localparam int INDEX_BITS     = 20;

    localparam int CELL_COUNT  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_BITS   = $clog2(CELL_COUNT);
    localparam int PROD_W      = ADDR_BITS + 1;
    localparam int MEM_W       = INDEX_BITS + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 6;
    localparam int INDEX_W  = 20;
    localparam int HW_W     = 3;
    localparam int DIM_W    = 7;
    localparam int SCOORD_W = COORD_W + 2;
    localparam int OFS_W    = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = DIM_W;
    localparam int ROWS_RESET  = 64;
    localparam int COLS_RESET  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = CFG_INDEX_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_ADD     = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_DIAMOND = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_PATCH   = FUNC_W'(3);

    typedef enum logic [1:0] {OP_ADD, OP_LOOKUP, OP_SCAN} op_t;

    typedef struct packed {
        op_t                   op;
        logic                  diamond;
        logic                  oog;
        logic [ADDR_BITS-1:0]  addr;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [INDEX_BITS-1:0] pidx;
        logic [HW_W-1:0]       hw;
    } cmd_t;

    typedef struct packed {
        logic                 ongrid;
        logic [ADDR_BITS-1:0] addr;
    } loc_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               oog;
    } rsp_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > max_v)
            r = DIM_W'(max_v);
        else
            r = v;
        return r;
    endfunction

    function automatic loc_t cell_locate(input logic signed [SCOORD_W-1:0] xs,
                                         input logic signed [SCOORD_W-1:0] ys,
                                         input logic [DIM_W-1:0] rows,
                                         input logic [DIM_W-1:0] cols);
        loc_t              r;
        logic [PROD_W-1:0] prod;
        r.ongrid = !xs[SCOORD_W-1] && !ys[SCOORD_W-1]
                   && (xs[SCOORD_W-2:0] < cols) && (ys[SCOORD_W-2:0] < rows);
        prod = PROD_W'(ys[COORD_W-1:0]) * PROD_W'(cols);
        r.addr = ADDR_BITS'(prod + PROD_W'(xs[COORD_W-1:0]));
        return r;
    endfunction

    function automatic rsp_t make_rsp(input logic found, input logic [INDEX_W-1:0] index,
                                      input logic last, input logic oog);
        rsp_t r;
        r.found = found;
        r.index = index;
        r.last  = last;
        r.oog   = oog;
        return r;
    endfunction

endpackage

// ===== hdl/gcnq_item_if.sv =====
// input item channel: valid/ready handshake with the request fields
// depends on gcnq_pkg
interface gcnq_item_if;
    import gcnq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [COORD_W-1:0]    coord_x;
    logic [COORD_W-1:0]    coord_y;
    logic [INDEX_W-1:0]    point_index;
    logic [HW_W-1:0]       half_width;

    modport source (output valid, func, coord_x, coord_y, point_index, half_width,
                    input ready);
    modport sink (input valid, func, coord_x, coord_y, point_index, half_width,
                  output ready);
endinterface

// ===== hdl/gcnq_result_if.sv =====
// result channel: valid/ready handshake with the result fields
// depends on gcnq_pkg
interface gcnq_result_if;
    import gcnq_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               last;
    logic               out_of_grid;

    modport source (output valid, found, found_index, last, out_of_grid, input ready);
    modport sink (input valid, found, found_index, last, out_of_grid, output ready);
endinterface

// ===== hdl/gcnq_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module gcnq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/gcnq_queue.sv =====
// short command queue between the front classifier and the back sequencer
// depends on gcnq_pkg
module gcnq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcnq_pkg::cmd_t  wr_cmd,
    output logic            full,
    output logic            valid,
    output gcnq_pkg::cmd_t  rd_cmd,
    input  logic            pop
);
    import gcnq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full   = count_reg == CNT_W'(QUEUE_DEPTH);
    assign valid  = count_reg != '0;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= wr_cmd;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

// ===== hdl/gcnq_front.sv =====
// front end: accepts items, decodes the function, resolves the cell address
// depends on gcnq_pkg and gcnq_item_if
module gcnq_front (
    input  logic                       clearing,
    input  logic [gcnq_pkg::DIM_W-1:0] rows,
    input  logic [gcnq_pkg::DIM_W-1:0] cols,
    gcnq_item_if.sink                  item,
    input  logic                       q_full,
    output logic                       push,
    output gcnq_pkg::cmd_t             cmd
);
    import gcnq_pkg::*;

    loc_t loc;

    assign item.ready = !q_full && !clearing;
    assign push       = item.valid && item.ready;

    always_comb
    begin
        loc = cell_locate(signed'({2'b00, item.coord_x}), signed'({2'b00, item.coord_y}),
                          rows, cols);
        cmd.diamond = item.func == FUNC_DIAMOND;
        cmd.oog     = !loc.ongrid;
        cmd.addr    = loc.addr;
        cmd.x       = item.coord_x;
        cmd.y       = item.coord_y;
        cmd.pidx    = item.point_index[INDEX_BITS-1:0];
        cmd.hw      = (item.half_width > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH)
                                                                 : item.half_width;
        unique case (item.func) inside
            FUNC_ADD:                 cmd.op = OP_ADD;
            FUNC_LOOKUP:              cmd.op = OP_LOOKUP;
            FUNC_DIAMOND, FUNC_PATCH: cmd.op = OP_SCAN;
            default:                  cmd.op = OP_ADD;
        endcase
    end
endmodule

// ===== hdl/gcnq_back.sv =====
// back end: clearing pass, cell writes and reads, neighborhood scan, result register
// depends on gcnq_pkg, gcnq_result_if and gcnq_ram
module gcnq_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [gcnq_pkg::DIM_W-1:0] rows,
    input  logic [gcnq_pkg::DIM_W-1:0] cols,
    input  logic                       q_valid,
    input  gcnq_pkg::cmd_t             q_cmd,
    output logic                       pop,
    output logic                       clearing,
    gcnq_result_if.source              result
);
    import gcnq_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_SCAN} state_t;

    state_t                      state_reg, state_next;
    logic [ADDR_BITS-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                        out_valid_reg, out_valid_next;
    rsp_t                        out_reg, out_next;
    logic [COORD_W-1:0]          x_reg, x_next;
    logic [COORD_W-1:0]          y_reg, y_next;
    logic [HW_W-1:0]             hw_reg, hw_next;
    logic                        diamond_reg, diamond_next;
    logic signed [OFS_W-1:0]     scan_col_offset_reg, scan_col_offset_next;
    logic signed [OFS_W-1:0]     scan_row_offset_reg, scan_row_offset_next;
    logic                        a_active_reg, a_active_next;
    logic                        b_valid_reg, b_valid_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [INDEX_BITS-1:0]       pend_index_reg, pend_index_next;

    logic                        ram_en, ram_we;
    logic [ADDR_BITS-1:0]        ram_addr;
    logic [MEM_W-1:0]            ram_wdata, ram_rdata;
    logic                        rd_v;
    logic [INDEX_BITS-1:0]       rd_idx;

    logic                        out_free, hit, stall, probe, keep_shape, end_row, end_col;
    logic signed [SCOORD_W-1:0]  xs, ys;
    logic [OFS_W-1:0]            col_abs, row_abs, abs_sum;
    logic signed [OFS_W-1:0]     hw_s, hw_m1;
    loc_t                        scan_loc;

    gcnq_ram #(.WIDTH(MEM_W), .DEPTH(CELL_COUNT)) u_cells (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_v     = ram_rdata[INDEX_BITS];
    assign rd_idx   = ram_rdata[INDEX_BITS-1:0];
    assign clearing = state_reg == ST_CLEAR;

    assign result.valid       = out_valid_reg;
    assign result.found       = out_reg.found;
    assign result.found_index = out_reg.index;
    assign result.last        = out_reg.last;
    assign result.out_of_grid = out_reg.oog;

    // scan probe address and shape filter
    always_comb
    begin
        hw_s  = signed'(OFS_W'(hw_reg));
        hw_m1 = hw_s - OFS_W'(1);
        xs = signed'({2'b00, x_reg}) + SCOORD_W'(scan_col_offset_reg);
        ys = signed'({2'b00, y_reg}) + SCOORD_W'(scan_row_offset_reg);
        scan_loc = cell_locate(xs, ys, rows, cols);
        col_abs = scan_col_offset_reg[OFS_W-1] ? OFS_W'(-scan_col_offset_reg)
                                               : OFS_W'(scan_col_offset_reg);
        row_abs = scan_row_offset_reg[OFS_W-1] ? OFS_W'(-scan_row_offset_reg)
                                               : OFS_W'(scan_row_offset_reg);
        abs_sum = col_abs + row_abs;
        keep_shape = !diamond_reg || (abs_sum < OFS_W'(hw_reg));
        probe   = keep_shape && scan_loc.ongrid;
        end_row = scan_row_offset_reg == hw_m1;
        end_col = scan_col_offset_reg == hw_m1;
    end

    assign out_free = !out_valid_reg || result.ready;
    assign hit      = b_valid_reg && rd_v;
    assign stall    = hit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next           = state_reg;
        clr_cnt_next         = clr_cnt_reg;
        out_valid_next       = out_valid_reg && !result.ready;
        out_next             = out_reg;
        x_next               = x_reg;
        y_next               = y_reg;
        hw_next              = hw_reg;
        diamond_next         = diamond_reg;
        scan_col_offset_next = scan_col_offset_reg;
        scan_row_offset_next = scan_row_offset_reg;
        a_active_next        = a_active_reg;
        b_valid_next         = b_valid_reg;
        pend_valid_next      = pend_valid_reg;
        pend_index_next      = pend_index_reg;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = q_cmd.addr;
        ram_wdata = '0;
        pop       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_BITS'(CELL_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_ADD:
                        begin
                            ram_en         = !q_cmd.oog;
                            ram_we         = 1'b1;
                            ram_wdata      = {1'b1, q_cmd.pidx};
                            out_valid_next = 1'b1;
                            out_next       = make_rsp(1'b0, '0, 1'b1, q_cmd.oog);
                        end
                        OP_LOOKUP:
                        begin
                            if (q_cmd.oog)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = make_rsp(1'b0, '0, 1'b1, 1'b1);
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                state_next = ST_LOOK;
                            end
                        end
                        OP_SCAN:
                        begin
                            if (q_cmd.hw == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = make_rsp(1'b0, '0, 1'b1, 1'b0);
                            end
                            else
                            begin
                                x_next               = q_cmd.x;
                                y_next               = q_cmd.y;
                                hw_next              = q_cmd.hw;
                                diamond_next         = q_cmd.diamond;
                                scan_col_offset_next = -signed'(OFS_W'(q_cmd.hw));
                                scan_row_offset_next = -signed'(OFS_W'(q_cmd.hw));
                                a_active_next        = 1'b1;
                                b_valid_next         = 1'b0;
                                state_next           = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = make_rsp(rd_v, rd_v ? INDEX_W'(rd_idx) : '0, 1'b1, 1'b0);
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (a_active_reg)
                    begin
                        ram_en       = probe;
                        ram_addr     = scan_loc.addr;
                        b_valid_next = probe;
                        if (end_col && end_row)
                        begin
                            a_active_next        = 1'b0;
                            scan_col_offset_next = '0;
                            scan_row_offset_next = '0;
                        end
                        else if (end_row)
                        begin
                            scan_row_offset_next = -hw_s;
                            scan_col_offset_next = scan_col_offset_reg + OFS_W'(1);
                        end
                        else
                            scan_row_offset_next = scan_row_offset_reg + OFS_W'(1);
                    end
                    else
                        b_valid_next = 1'b0;

                    // one hit held back so the final one can carry the last marker
                    if (hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_index_next = rd_idx;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next = make_rsp(1'b1, INDEX_W'(pend_index_reg), 1'b0, 1'b0);
                        end
                    end
                end
                if (!a_active_reg && !b_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next = make_rsp(pend_valid_reg,
                                        pend_valid_reg ? INDEX_W'(pend_index_reg) : '0,
                                        1'b1, 1'b0);
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_CLEAR;
            clr_cnt_reg         <= '0;
            out_valid_reg       <= 1'b0;
            out_reg             <= '0;
            x_reg               <= '0;
            y_reg               <= '0;
            hw_reg              <= '0;
            diamond_reg         <= 1'b0;
            scan_col_offset_reg <= '0;
            scan_row_offset_reg <= '0;
            a_active_reg        <= 1'b0;
            b_valid_reg         <= 1'b0;
            pend_valid_reg      <= 1'b0;
            pend_index_reg      <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            clr_cnt_reg         <= clr_cnt_next;
            out_valid_reg       <= out_valid_next;
            out_reg             <= out_next;
            x_reg               <= x_next;
            y_reg               <= y_next;
            hw_reg              <= hw_next;
            diamond_reg         <= diamond_next;
            scan_col_offset_reg <= scan_col_offset_next;
            scan_row_offset_reg <= scan_row_offset_next;
            a_active_reg        <= a_active_next;
            b_valid_reg         <= b_valid_next;
            pend_valid_reg      <= pend_valid_next;
            pend_index_reg      <= pend_index_next;
        end
    end
endmodule

// ===== hdl/grid_cell_index_store_neighborhood_query_top.sv =====
// grid cell index store with neighborhood queries; one cell per ram entry.
// a lookup or a query holds the back end until its last result (a query with w of 0 gives one empty result);
// the single ram port probes one offset a cycle while no stall holds the scan.
// throughput: one add per cycle while results are taken.
// after reset a clearing pass writes all 4096 cells empty, item ready low.
// depends on gcnq_pkg, gcnq_item_if, gcnq_result_if, gcnq_queue, gcnq_front, gcnq_back
module grid_cell_index_store_neighborhood_query_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gcnq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcnq_pkg::CFG_DATA_W-1:0]  cfg_data,
    gcnq_item_if.sink                        item,
    gcnq_result_if.source                    result
);
    import gcnq_pkg::*;

    logic [DIM_W-1:0] grid_rows_reg;
    logic [DIM_W-1:0] grid_cols_reg;
    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;

    logic             clearing;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    cmd_t             wr_cmd;
    cmd_t             rd_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= DIM_W'(ROWS_RESET);
            grid_cols_reg <= DIM_W'(COLS_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[DIM_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign rows_eff = clamp_dim(grid_rows_reg, MAX_ROWS);
    assign cols_eff = clamp_dim(grid_cols_reg, MAX_COLS);

    gcnq_front u_front (
        .clearing (clearing),
        .rows     (rows_eff),
        .cols     (cols_eff),
        .item     (item),
        .q_full   (q_full),
        .push     (push),
        .cmd      (wr_cmd)
    );

    gcnq_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .full   (q_full),
        .valid  (q_valid),
        .rd_cmd (rd_cmd),
        .pop    (pop)
    );

    gcnq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rows     (rows_eff),
        .cols     (cols_eff),
        .q_valid  (q_valid),
        .q_cmd    (rd_cmd),
        .pop      (pop),
        .clearing (clearing),
        .result   (result)
    );

    a_clear_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !item.ready)
        else $error("item ready during clearing pass");

    a_clear_no_results: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !result.valid && !q_valid)
        else $error("work pending during clearing pass");

    a_oog_single: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.out_of_grid |-> !result.found && result.last)
        else $error("off-grid result not a single empty result");

    a_miss_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.found_index == '0 && result.last)
        else $error("miss result carries an index or lacks last");
endmodule
